// ===== hdl/rtdc_pkg.sv =====
// shared types and constants of the rtd code to temperature converter
`default_nettype none

package rtdc_pkg;

	// field and register widths
	localparam int CODE_W = 15;
	localparam int NOM_W  = 10;
	localparam int REF_W  = 14;
	localparam int N_W    = 29;
	localparam int M_W    = 25;
	localparam int W_W    = 28;
	localparam int E_W    = 57;
	localparam int P_W    = 36;

	// configuration register indexes
	localparam logic CFG_RTD_NOMINAL  = 1'b0;
	localparam logic CFG_REF_RESISTOR = 1'b1;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// callendar-van dusen constants, scaled
	localparam logic [30:0] CVD_K     = 31'd1527480889;
	localparam logic [27:0] CVD_B4    = 28'd231000000;
	localparam logic [31:0] CVD_AQ    = 32'd2561343488;
	localparam logic [24:0] CVD_SCALE = 25'd20000000;
	localparam logic [26:0] BIG_K     = 27'd67108865;

	// divider and root sizes
	localparam int UQ_QB      = 35;
	localparam int F_QB       = 63;
	localparam int RQ_QB      = 27;
	localparam int SQ_IN_W    = 64;
	localparam int SQ_OUT_W   = SQ_IN_W / 2;
	localparam int NN_W       = 61;
	localparam int POLY_STEPS = 5;

	// polynomial coefficients, c_k scaled by 2^(10k+16)
	localparam int ACC_W = 36;
	localparam logic signed [ACC_W-1:0] POLY_COEF [6] = '{
		-36'sd15861023, 36'sd149169583, 36'sd177701695,
		-36'sd339599559, -36'sd2030799173, 36'sd11247348797
	};

	typedef struct packed {
		logic [M_W-1:0] m;
		logic [W_W-1:0] w;
		logic [E_W-1:0] e;
		logic [P_W-1:0] p;
		logic           root;
		logic           big;
	} item_t;

	typedef struct packed {
		logic               empty;
		logic [FIFO_AW:0]   count;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rtdc_front.sv =====
// front end: config registers, resistance products and path classification
`default_nettype none

module rtdc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [rtdc_pkg::CODE_W-1:0]   rtd_code,
	input  wire logic                          code_valid,
	output logic                               code_stall,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [rtdc_pkg::REF_W-1:0]    cfg_data,
	input  rtdc_pkg::fifo_stat_t               fifo_stat,
	output logic                               wr_en,
	output rtdc_pkg::item_t                    wr_item
);

	logic [rtdc_pkg::NOM_W-1:0] nom_q;
	logic [rtdc_pkg::REF_W-1:0] ref_q;
	logic                       valid_s1;
	logic [rtdc_pkg::N_W-1:0]   n_s1;
	logic [rtdc_pkg::M_W-1:0]   m_s1;
	logic [rtdc_pkg::NOM_W-1:0] nom_eff;
	logic                       accept;
	logic [rtdc_pkg::N_W-1:0]   w_full;
	logic [rtdc_pkg::E_W-1:0]   prod_k;
	logic [rtdc_pkg::E_W-1:0]   prod_b;
	logic [rtdc_pkg::P_W-1:0]   p;
	logic                       ge;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q <= rtdc_pkg::NOM_W'(100);
			ref_q <= rtdc_pkg::REF_W'(430);
		end else if (cfg_valid) begin
			case (cfg_index)
				rtdc_pkg::CFG_RTD_NOMINAL:  nom_q <= cfg_data[rtdc_pkg::NOM_W-1:0];
				rtdc_pkg::CFG_REF_RESISTOR: ref_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// keep one slot free for the word in s1
	assign code_stall = fifo_stat.count >= (rtdc_pkg::FIFO_AW+1)'(rtdc_pkg::FIFO_DEPTH - 1);
	assign accept     = code_valid && !code_stall;
	assign nom_eff    = (nom_q == '0) ? rtdc_pkg::NOM_W'(1) : nom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_s1 <= rtdc_pkg::N_W'(rtd_code) * rtdc_pkg::N_W'(ref_q);
			m_s1 <= {nom_eff, 15'b0};
		end
	end

	// root usable when x >= 1 and the discriminant is not negative
	assign ge     = n_s1 >= rtdc_pkg::N_W'(m_s1);
	assign w_full = n_s1 - rtdc_pkg::N_W'(m_s1);
	assign prod_k = rtdc_pkg::E_W'(rtdc_pkg::CVD_K) * rtdc_pkg::E_W'(m_s1);
	assign prod_b = rtdc_pkg::E_W'(rtdc_pkg::CVD_B4) * rtdc_pkg::E_W'(w_full);
	assign p      = rtdc_pkg::P_W'(n_s1) * rtdc_pkg::P_W'(100);

	assign wr_en        = valid_s1;
	assign wr_item.m    = m_s1;
	assign wr_item.w    = w_full[rtdc_pkg::W_W-1:0];
	assign wr_item.e    = prod_k - prod_b;
	assign wr_item.p    = p;
	assign wr_item.root = ge && (prod_k >= prod_b);
	// ratio above 1024: polynomial input pinned there
	assign wr_item.big  = {p, 16'b0} >= (52'(rtdc_pkg::BIG_K) * 52'(m_s1));

endmodule

`default_nettype wire

// ===== hdl/rtdc_fifo.sv =====
// short word queue between front and back
`default_nettype none

module rtdc_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  rtdc_pkg::item_t      wr_item,
	input  wire logic            rd_en,
	output rtdc_pkg::item_t      rd_item,
	output rtdc_pkg::fifo_stat_t fifo_stat
);

	rtdc_pkg::item_t                  mem_q [rtdc_pkg::FIFO_DEPTH];
	logic [rtdc_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [rtdc_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [rtdc_pkg::FIFO_AW:0]       count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_item         = mem_q[rd_ptr_q];
	assign fifo_stat.empty = (count_q == '0);
	assign fifo_stat.count = count_q;

endmodule

`default_nettype wire

// ===== hdl/rtdc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module rtdc_div #(
	parameter int NUM_W = 60,
	parameter int DEN_W = 25,
	parameter int Q_W   = 35
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo
);

	localparam int HI_W = NUM_W - Q_W;

	logic [DEN_W-1:0] rem_q [Q_W-1];
	logic [DEN_W-1:0] den_q [Q_W-1];
	logic [Q_W-1:0]   lo_q  [Q_W-1];
	logic [Q_W-1:0]   quo_q [Q_W];
	logic [HI_W+DEN_W-1:0] hi_ext;

	// upper numerator bits preload the remainder
	assign hi_ext = {{DEN_W{1'b0}}, num[NUM_W-1:Q_W]};

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   lo_in;
		logic [Q_W-1:0]   quo_in;
		logic [DEN_W:0]   trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_in = hi_ext[DEN_W-1:0];
			assign den_in = den;
			assign lo_in  = num[Q_W-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign lo_in  = lo_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign trial = {rem_in, lo_in[Q_W-1-k]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= {quo_in[Q_W-2:0], take};
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
					den_q[k] <= den_in;
					lo_q[k]  <= lo_in;
				end
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/rtdc_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none

module rtdc_sqrt #(
	parameter int IN_W = 64
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [IN_W-1:0]   val,
	output logic      [IN_W/2-1:0] root
);

	localparam int OUT_W = IN_W / 2;
	localparam int REM_W = OUT_W + 2;

	logic [REM_W-1:0] rem_q  [OUT_W-1];
	logic [IN_W-1:0]  val_q  [OUT_W-1];
	logic [OUT_W-1:0] root_q [OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_step
		logic [REM_W-1:0] rem_in;
		logic [IN_W-1:0]  val_in;
		logic [OUT_W-1:0] root_in;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] sub;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign val_in  = val;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign val_in  = val_q[k-1];
			assign root_in = root_q[k-1];
		end

		assign trial = {rem_in, val_in[IN_W-1-2*k -: 2]};
		assign sub   = (REM_W+2)'({root_in, 2'b01});
		assign take  = trial >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[k] <= {root_in[OUT_W-2:0], take};
			end
		end

		if (k < OUT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= take ? REM_W'(trial - sub) : trial[REM_W-1:0];
					val_q[k] <= val_in;
				end
			end
		end
	end

	assign root = root_q[OUT_W-1];

endmodule

`default_nettype wire

// ===== hdl/rtdc_back.sv =====
// back end: root and polynomial datapaths, saturation and output register
`default_nettype none

module rtdc_back #(
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  rtdc_pkg::item_t                    head,
	input  rtdc_pkg::fifo_stat_t               fifo_stat,
	output logic                               pop,
	output logic                               temp_valid,
	input  wire logic                          temp_stall,
	output logic signed [FRACTION_BITS+10:0]   temperature_q8,
	output logic                               saturated,
	output logic                               used_polynomial
);

	localparam int TW      = FRACTION_BITS + 11;
	localparam int SH      = 16 - FRACTION_BITS;
	localparam int QF      = FRACTION_BITS + 13;
	localparam int DD_W    = 33 + SH;
	localparam int ACC_W   = rtdc_pkg::ACC_W;
	localparam int ROOT_AT = rtdc_pkg::F_QB + rtdc_pkg::SQ_OUT_W;
	localparam int UQ_DLY  = ROOT_AT - rtdc_pkg::UQ_QB;
	localparam int BIG_DLY = rtdc_pkg::RQ_QB;
	localparam int CTL_DLY = ROOT_AT + 1 + QF;
	localparam int TP_DLY  = CTL_DLY - (rtdc_pkg::RQ_QB + rtdc_pkg::POLY_STEPS + 1);
	localparam logic signed [TW-1:0] HI_T = {1'b0, {(TW-1){1'b1}}};
	localparam logic signed [TW-1:0] LO_T = {3'b111, {(TW-3){1'b0}}};
	localparam logic signed [ACC_W-1:0] HI_A = {{(ACC_W-TW){1'b0}}, HI_T};
	localparam logic signed [ACC_W-1:0] LO_A = {{(ACC_W-TW){1'b1}}, LO_T};

	logic                               adv;
	logic                               valid_q;
	logic [rtdc_pkg::UQ_QB-1:0]         uq;
	logic [rtdc_pkg::F_QB-1:0]          f;
	logic [rtdc_pkg::RQ_QB-1:0]         rq;
	logic [rtdc_pkg::SQ_OUT_W-1:0]      sq;
	logic [rtdc_pkg::UQ_QB-1:0]         uq_dl_q  [UQ_DLY];
	logic                               big_dl_q [BIG_DLY];
	logic                               vld_dl_q [CTL_DLY];
	logic                               root_dl_q [CTL_DLY];
	logic signed [ACC_W-1:0]            tp_dl_q  [TP_DLY];
	logic [32:0]                        base;
	logic [DD_W-1:0]                    dd;
	logic [DD_W-1:0]                    dd_q;
	logic [rtdc_pkg::NN_W-1:0]          nn_q;
	logic [QF-1:0]                      t_root;
	logic [rtdc_pkg::RQ_QB-1:0]         s_clamp;
	logic signed [ACC_W-1:0]            acc_q [rtdc_pkg::POLY_STEPS];
	logic [rtdc_pkg::RQ_QB-1:0]         s_q   [rtdc_pkg::POLY_STEPS-1];
	logic signed [ACC_W-1:0]            tp;
	logic signed [ACC_W-1:0]            tp_q;
	logic signed [ACC_W-1:0]            tp_d;
	logic signed [TW-1:0]               t_sel;
	logic                               sat;

	// whole back end moves while the output register can take a word
	assign adv = !valid_q || !temp_stall;
	assign pop = adv && !fifo_stat.empty;

	// first divisions: (x-1), discriminant and 100x, all over m
	rtdc_div #(
		.NUM_W(rtdc_pkg::W_W + 32), .DEN_W(rtdc_pkg::M_W), .Q_W(rtdc_pkg::UQ_QB)
	) u_div_uq (
		.clk(clk), .en(adv), .num({head.w, 32'b0}), .den(head.m), .quo(uq)
	);

	rtdc_div #(
		.NUM_W(rtdc_pkg::E_W + 32), .DEN_W(rtdc_pkg::M_W), .Q_W(rtdc_pkg::F_QB)
	) u_div_f (
		.clk(clk), .en(adv), .num({head.e, 32'b0}), .den(head.m), .quo(f)
	);

	rtdc_div #(
		.NUM_W(rtdc_pkg::P_W + 16), .DEN_W(rtdc_pkg::M_W), .Q_W(rtdc_pkg::RQ_QB)
	) u_div_rq (
		.clk(clk), .en(adv), .num({head.p, 16'b0}), .den(head.m), .quo(rq)
	);

	rtdc_sqrt #(
		.IN_W(rtdc_pkg::SQ_IN_W)
	) u_sqrt (
		.clk(clk), .en(adv), .val(rtdc_pkg::SQ_IN_W'(f)), .root(sq)
	);

	// delay lines that line the paths up
	always_ff @(posedge clk) begin
		if (adv) begin
			uq_dl_q[0]   <= uq;
			big_dl_q[0]  <= head.big;
			root_dl_q[0] <= head.root;
			tp_dl_q[0]   <= tp_q;
			for (int i = 1; i < UQ_DLY; i++) begin
				uq_dl_q[i] <= uq_dl_q[i-1];
			end
			for (int i = 1; i < BIG_DLY; i++) begin
				big_dl_q[i] <= big_dl_q[i-1];
			end
			for (int i = 1; i < CTL_DLY; i++) begin
				root_dl_q[i] <= root_dl_q[i-1];
			end
			for (int i = 1; i < TP_DLY; i++) begin
				tp_dl_q[i] <= tp_dl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CTL_DLY; i++) begin
				vld_dl_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_dl_q[0] <= pop;
			for (int i = 1; i < CTL_DLY; i++) begin
				vld_dl_q[i] <= vld_dl_q[i-1];
			end
		end
	end

	// root path: T = 2e7*uq / ((A*2^16 + sqrt) << sh), rounded half up
	assign base = 33'(rtdc_pkg::CVD_AQ) + 33'(sq);
	assign dd   = DD_W'(base) << SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			nn_q <= rtdc_pkg::NN_W'(uq_dl_q[UQ_DLY-1]) * rtdc_pkg::NN_W'(rtdc_pkg::CVD_SCALE)
				+ rtdc_pkg::NN_W'(dd[DD_W-1:1]);
			dd_q <= dd;
		end
	end

	rtdc_div #(
		.NUM_W(rtdc_pkg::NN_W), .DEN_W(DD_W), .Q_W(QF)
	) u_div_t (
		.clk(clk), .en(adv), .num(nn_q), .den(dd_q), .quo(t_root)
	);

	// polynomial path: horner steps, one multiply per stage
	assign s_clamp = big_dl_q[BIG_DLY-1] ? rtdc_pkg::RQ_QB'(1 << 26) : rq;

	for (genvar j = 0; j < rtdc_pkg::POLY_STEPS; j++) begin : g_horner
		logic signed [ACC_W-1:0]             acc_in;
		logic [rtdc_pkg::RQ_QB-1:0]          s_in;
		logic signed [ACC_W+rtdc_pkg::RQ_QB:0] prod;

		if (j == 0) begin : g_first
			assign acc_in = rtdc_pkg::POLY_COEF[5];
			assign s_in   = s_clamp;
		end else begin : g_next
			assign acc_in = acc_q[j-1];
			assign s_in   = s_q[j-1];
		end

		assign prod = acc_in * $signed({1'b0, s_in});

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_q[j] <= rtdc_pkg::POLY_COEF[4-j] + ACC_W'(prod >>> 26);
			end
		end

		if (j < rtdc_pkg::POLY_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					s_q[j] <= s_in;
				end
			end
		end
	end

	if (SH == 0) begin : g_no_round
		assign tp = acc_q[rtdc_pkg::POLY_STEPS-1];
	end else begin : g_round
		localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (SH - 1);
		assign tp = (acc_q[rtdc_pkg::POLY_STEPS-1] + RND) >>> SH;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tp_q <= tp;
		end
	end

	assign tp_d = tp_dl_q[TP_DLY-1];

	// path select and clamp to -256 .. 1024 C
	always_comb begin
		sat   = 1'b0;
		t_sel = HI_T;
		if (root_dl_q[CTL_DLY-1]) begin
			sat   = |t_root[QF-1:TW-1];
			t_sel = sat ? HI_T : $signed(t_root[TW-1:0]);
		end else if (tp_d > HI_A) begin
			sat   = 1'b1;
			t_sel = HI_T;
		end else if (tp_d < LO_A) begin
			sat   = 1'b1;
			t_sel = LO_T;
		end else begin
			t_sel = tp_d[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= vld_dl_q[CTL_DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature_q8  <= t_sel;
			saturated       <= sat;
			used_polynomial <= !root_dl_q[CTL_DLY-1];
		end
	end

	assign temp_valid = valid_q;

endmodule

`default_nettype wire

// ===== hdl/rtd_code_to_temperature_top.sv =====
// top level of the rtd ratio code to temperature converter
//
// channel   dir  handshake            payload
// cfg       in   cfg_valid/cfg_ready  cfg_index (0 nominal ohms, 1 ref ohms), cfg_data
// code      in   code_valid/code_stall rtd_code
// temp      out  temp_valid/temp_stall temperature_q8, saturated, used_polynomial
//
// one word accepted per cycle when the output side keeps up
// from code accept to temp_valid a word passes through the chain of bit-serial divider
//   stages, the 32-stage square root and the final divide
// a word stays on the temp port while temp_stall is high; the back end freezes and
//   the 4-word queue fills, code_stall rising once it holds three words
// reset loads 100 ohms nominal and 430 ohms reference; cfg writes are taken at once
// write cfg only while no conversion is in flight
`default_nettype none

module rtd_code_to_temperature_top #(
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// register writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [rtdc_pkg::REF_W-1:0]    cfg_data,
	// ratio codes in
	input  wire logic [rtdc_pkg::CODE_W-1:0]   rtd_code,
	input  wire logic                          code_valid,
	output logic                               code_stall,
	// temperatures out
	output logic signed [FRACTION_BITS+10:0]   temperature_q8,
	output logic                               saturated,
	output logic                               used_polynomial,
	output logic                               temp_valid,
	input  wire logic                          temp_stall
);

	logic                 wr_en;
	rtdc_pkg::item_t      wr_item;
	rtdc_pkg::item_t      head;
	rtdc_pkg::fifo_stat_t fifo_stat;
	logic                 pop;

	// front: config, n = code*ref, classify root or polynomial
	rtdc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rtd_code(rtd_code),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fifo_stat(fifo_stat),
		.wr_en(wr_en),
		.wr_item(wr_item)
	);

	// decouples front from back so each can stall alone
	rtdc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_item(wr_item),
		.rd_en(pop),
		.rd_item(head),
		.fifo_stat(fifo_stat)
	);

	// back: both paths computed for every word, selected and clamped at the end
	rtdc_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.fifo_stat(fifo_stat),
		.pop(pop),
		.temp_valid(temp_valid),
		.temp_stall(temp_stall),
		.temperature_q8(temperature_q8),
		.saturated(saturated),
		.used_polynomial(used_polynomial)
	);

endmodule

`default_nettype wire

// ===== verif/tb_rtd_code_to_temperature_top.sv =====
// testbench for the rtd ratio code to temperature converter: directed and random codes, checked per word
`timescale 1ns / 100ps
`default_nettype none

module tb_rtd_code_to_temperature_top;

	localparam int FB = 8;
	localparam int TW = FB + 11;
	localparam int LAT = FB + 111;

	// polynomial coefficients, c_k scaled by 2^(10k+16)
	localparam longint PC0 = -64'sd15861023;
	localparam longint PC1 = 64'sd149169583;
	localparam longint PC2 = 64'sd177701695;
	localparam longint PC3 = -64'sd339599559;
	localparam longint PC4 = -64'sd2030799173;
	localparam longint PC5 = 64'sd11247348797;

	typedef struct packed {
		logic [TW-1:0] temp;
		logic          sat;
		logic          poly;
	} temp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = rtdc_pkg::CFG_RTD_NOMINAL;
	logic [rtdc_pkg::REF_W-1:0] cfg_data = '0;
	logic [rtdc_pkg::CODE_W-1:0] rtd_code = '0;
	logic code_valid = 1'b0;
	logic code_stall;
	logic signed [FB+10:0] temperature_q8;
	logic saturated, used_polynomial, temp_valid;
	logic temp_stall = 1'b0;

	// mirror of the two registers
	logic [rtdc_pkg::NOM_W-1:0] nominal_ohms = 10'd100;
	logic [rtdc_pkg::REF_W-1:0] ref_ohms = 14'd430;

	logic [rtdc_pkg::CODE_W-1:0] pending_codes[$];
	temp_word_t expected_temps[$];
	int mismatches = 0;
	int words_checked = 0;
	int poly_seen = 0, sat_seen = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int burst_left = 0, gap_left = 0;

	always #5 clk = ~clk;

	rtd_code_to_temperature_top #(.FRACTION_BITS(FB)) u_top (.*);

	function automatic longint floor_sh(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else
				res >>= 1;
			bit_v >>= 2;
		end
		return res;
	endfunction

	// conversion of one code under the current register values
	function automatic temp_word_t convert_code(logic [rtdc_pkg::CODE_W-1:0] code);
		longint unsigned nom, n, m, e, f, sq, uq, num, d, rq;
		longint t, s, acc;
		longint hi, lo;
		temp_word_t w;
		nom = (nominal_ohms == 0) ? 1 : nominal_ohms;
		n = code * ref_ohms;
		m = 64'd32768 * nom;
		hi = (64'sd1024 << FB) - 1;
		lo = -(64'sd256 << FB);
		w.poly = 1'b1;
		w.sat = 1'b0;
		if (n >= m && 64'd1527480889 * m >= 64'd231000000 * (n - m)) begin
			e = 64'd1527480889 * m - 64'd231000000 * (n - m);
			f = ((e / m) << 32) + (((e % m) << 32) / m);
			sq = int_sqrt(f);
			uq = (((n - m) / m) << 32) + ((((n - m) % m) << 32) / m);
			num = uq * 64'd20000000;
			d = (64'd39083 * 64'd65536 + sq) << (16 - FB);
			t = longint'((num + (d >> 1)) / d);
			w.poly = 1'b0;
		end else begin
			rq = ((64'd100 * n) << 16) / m;
			if (rq > (64'd1024 << 16)) rq = 64'd1024 << 16;
			s = longint'(rq);
			acc = PC5;
			acc = PC4 + floor_sh(acc * s, 26);
			acc = PC3 + floor_sh(acc * s, 26);
			acc = PC2 + floor_sh(acc * s, 26);
			acc = PC1 + floor_sh(acc * s, 26);
			acc = PC0 + floor_sh(acc * s, 26);
			t = floor_sh(acc + (64'sd1 << (15 - FB)), 16 - FB);
		end
		if (t > hi) begin
			t = hi;
			w.sat = 1'b1;
		end else if (t < lo) begin
			t = lo;
			w.sat = 1'b1;
		end
		w.temp = t[TW-1:0];
		return w;
	endfunction

	// driver: bursts of codes with random gaps, payload held while stalled
	always @(posedge clk) begin
		if (code_valid && !code_stall) begin
			expected_temps.push_back(convert_code(rtd_code));
		end
		if (!code_valid || !code_stall) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				code_valid <= 1'b0;
			end else if (pending_codes.size() > 0 && arst_n) begin
				rtd_code <= pending_codes.pop_front();
				code_valid <= 1'b1;
				if (burst_left > 0)
					burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end
			end else
				code_valid <= 1'b0;
		end
	end

	// monitor: compare each word with the oldest expectation
	always @(posedge clk) begin
		temp_word_t exp_w;
		if (temp_valid && !temp_stall) begin
			if (expected_temps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: temp %h sat %b poly %b",
						temperature_q8, saturated, used_polynomial);
			end else begin
				exp_w = expected_temps.pop_front();
				words_checked++;
				if (exp_w.poly) poly_seen++;
				if (exp_w.sat) sat_seen++;
				if (temperature_q8 !== exp_w.temp || saturated !== exp_w.sat ||
						used_polynomial !== exp_w.poly) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b/%b got %h/%b/%b",
							exp_w.temp, exp_w.sat, exp_w.poly,
							temperature_q8, saturated, used_polynomial);
				end
			end
		end
	end

	// receiver stall pattern; a requested hold-off is counted down here
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= 300;
			temp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			temp_stall <= 1'b1;
		end else case ($urandom_range(0, 3))
			0: temp_stall <= ($urandom_range(0, 1) == 1);
			default: temp_stall <= 1'b0;
		endcase
	end

	// register write, only while idle
	task automatic write_reg(logic idx, logic [rtdc_pkg::REF_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == rtdc_pkg::CFG_RTD_NOMINAL) nominal_ohms = val[rtdc_pkg::NOM_W-1:0];
		else ref_ohms = val;
	endtask

	task automatic drain();
		while (pending_codes.size() > 0 || code_valid || expected_temps.size() > 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	// codes near r = 100 (zero degrees) and spread over the range
	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: pending_codes.push_back(15'($urandom_range(0, 32767)));
				1: pending_codes.push_back(15'($urandom_range(7000, 8200)));
				2: pending_codes.push_back(15'($urandom_range(7600, 7640)));
				default: pending_codes.push_back($urandom_range(0, 1) ? 15'h7fff : 15'h0);
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero degree point, both paths, saturation
		pending_codes.push_back(15'h0000);
		pending_codes.push_back(15'h7fff);
		pending_codes.push_back(15'h0001);
		pending_codes.push_back(15'h4000);
		pending_codes.push_back(15'd7620);
		pending_codes.push_back(15'd7621);
		pending_codes.push_back(15'd7000);
		pending_codes.push_back(15'd20000);
		pending_codes.push_back(15'h5555);
		pending_codes.push_back(15'h2aaa);
		drain();

		// long receiver hold-off while codes keep coming, enough to fill the pipe
		queue_random(250);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		@(posedge clk);
		while (hold_left > 0)
			@(posedge clk);
		drain();

		// register settings, extremes included
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'd0);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'd1); end
				1: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'd1000);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'd4300); end
				2: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'h3ff);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'h3fff); end
				3: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'd100);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'd0); end
				4: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'd1);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'd10000); end
				5: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'($urandom_range(100, 1000)));
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'($urandom_range(1, 10000))); end
				6: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'h2aa);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'h1555); end
				default: begin write_reg(rtdc_pkg::CFG_RTD_NOMINAL, 14'd100);
					write_reg(rtdc_pkg::CFG_REF_RESISTOR, 14'd430); end
			endcase
			queue_random(phase == 7 ? 240 : 150);
			drain();
		end

		$display("checked %0d temperature words, %0d from the polynomial path, %0d clamped",
			words_checked, poly_seen, sat_seen);
		$display("covered eight register settings and one long output hold-off");
		if (mismatches == 0 && expected_temps.size() == 0)
			$display("tb_rtd_code_to_temperature_top: PASS");
		else
			$display("tb_rtd_code_to_temperature_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_rtd_code_to_temperature_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/rtdc_pkg.sv
hdl/rtdc_front.sv
hdl/rtdc_fifo.sv
hdl/rtdc_div.sv
hdl/rtdc_sqrt.sv
hdl/rtdc_back.sv
hdl/rtd_code_to_temperature_top.sv
verif/tb_rtd_code_to_temperature_top.sv
